[hw/rtl/mhpq_pkg.sv]
// Shared types and constants for the min-heap priority queue.
package mhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KEY_W = 32;
    localparam int TAG_W = 24;
    localparam int ENT_W = KEY_W + TAG_W;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_PUSH = 2'd0;
    localparam func_t FUNC_EXTRACT = 2'd1;
    localparam func_t FUNC_DECREASE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_DONE = 2'd0;
    localparam status_t ST_EXTRACTED = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FULL = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_EX_RD,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_CMP,
        S_SC_RD,
        S_SC_WAIT,
        S_SC_CMP,
        S_OUT
    } state_t;

endpackage

[hw/rtl/min_heap_priority_queue.sv]
// Top level: binary min-heap priority queue with decrease-key.
// Push writes the new entry at the end and sifts it up; extract returns the root, moves
// the last entry there and sifts it down; empty, full and unused code go straight to the
// result. Decrease-key scans every stored entry and sifts each match up.
// Throughput: one word at a time; the next is taken once the result is accepted.
// Reset (aresetn low, synchronous) empties the heap and clears the counter.
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_func,
    input  logic signed [KEY_W-1:0] s_key,
    input  logic [TAG_W-1:0]        s_target_tag,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic signed [KEY_W-1:0] m_min_key,
    output logic [TAG_W-1:0]        m_min_tag
);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TAG_W-1:0] opc_reg, opc_next;
    logic [AW-1:0] pos_reg, pos_next;     // node being sifted
    logic [CW-1:0] scan_reg, scan_next;   // decrease-key scan index
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tgt_reg, tgt_next;
    logic [1:0] st_reg, st_next;
    logic signed [KEY_W-1:0] okey_reg, okey_next;
    logic [TAG_W-1:0] otag_reg, otag_next;
    logic ov_reg, ov_next;
    logic fromscan_reg, fromscan_next;

    logic we;
    logic [AW-1:0] waddr, ra, rb;
    logic [ENT_W-1:0] wdata, rda, rdb;

    mhpq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb)
    );

    // Unpacked views of read data
    logic signed [KEY_W-1:0] ka, kb;
    logic [TAG_W-1:0] ta, tb;
    assign ka = rda[ENT_W-1:TAG_W];
    assign ta = rda[TAG_W-1:0];
    assign kb = rdb[ENT_W-1:TAG_W];
    assign tb = rdb[TAG_W-1:0];

    // Tree index helpers
    logic [AW-1:0] parent;
    logic [CW:0] lchild, rchild;
    assign parent = AW'((pos_reg - 1'b1) >> 1);
    assign lchild = {1'b0, pos_reg, 1'b1};
    assign rchild = lchild + 1'b1;

    // Sift-down holds the parent entry in pk/pt while rda/rdb read the two children
    logic signed [KEY_W-1:0] pk_reg, pk_next;
    logic [TAG_W-1:0] pt_reg, pt_next;
    logic dn_phase_reg, dn_phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            opc_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            opc_reg <= opc_next;
            ov_reg <= ov_next;
        end
        pos_reg <= pos_next;
        scan_reg <= scan_next;
        key_reg <= key_next;
        tgt_reg <= tgt_next;
        st_reg <= st_next;
        okey_reg <= okey_next;
        otag_reg <= otag_next;
        fromscan_reg <= fromscan_next;
        pk_reg <= pk_next;
        pt_reg <= pt_next;
        dn_phase_reg <= dn_phase_next;
    end

    assign s_ready = (state_reg == S_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_status = st_reg;
    assign m_min_key = okey_reg;
    assign m_min_tag = otag_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        opc_next = opc_reg;
        pos_next = pos_reg;
        scan_next = scan_reg;
        key_next = key_reg;
        tgt_next = tgt_reg;
        st_next = st_reg;
        okey_next = okey_reg;
        otag_next = otag_reg;
        ov_next = ov_reg;
        fromscan_next = fromscan_reg;
        pk_next = pk_reg;
        pt_next = pt_reg;
        dn_phase_next = dn_phase_reg;
        we = 1'b0;
        waddr = pos_reg;
        wdata = '0;
        ra = pos_reg;
        rb = parent;
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    opc_next = opc_reg + 1'b1;
                    key_next = s_key;
                    tgt_next = s_target_tag;
                    st_next = ST_DONE;
                    okey_next = '0;
                    otag_next = '0;
                    fromscan_next = 1'b0;
                    unique case (s_func)
                        FUNC_PUSH: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                st_next = ST_FULL;
                                state_next = S_OUT;
                            end else begin
                                we = 1'b1;
                                waddr = AW'(count_reg);
                                wdata = {s_key, opc_reg + 1'b1};
                                pos_next = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                                state_next = S_UP_RD;
                            end
                        end
                        FUNC_EXTRACT: begin
                            if (count_reg == '0) begin
                                st_next = ST_EMPTY;
                                state_next = S_OUT;
                            end else begin
                                st_next = ST_EXTRACTED;
                                state_next = S_EX_RD;
                            end
                        end
                        FUNC_DECREASE: begin
                            scan_next = '0;
                            state_next = S_SC_RD;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            // Sift-up: read node and parent
            S_UP_RD: begin
                if (pos_reg == '0) begin
                    state_next = fromscan_reg ? S_SC_RD : S_OUT;
                end else begin
                    ra = pos_reg;
                    rb = parent;
                    state_next = S_UP_WAIT;
                end
            end
            S_UP_WAIT: begin
                ra = pos_reg;
                rb = parent;
                state_next = S_UP_CMP;
            end
            S_UP_CMP: begin
                if ((ka < kb) || ((ka == kb) && (ta < tb))) begin
                    we = 1'b1;
                    waddr = parent;
                    wdata = rda;
                    pk_next = kb;
                    pt_next = tb;
                    dn_phase_next = 1'b1;
                    state_next = S_DN_WAIT; // reuse as "write lower node" step
                end else begin
                    state_next = fromscan_reg ? S_SC_RD : S_OUT;
                end
            end
            // Extract: read root and last entry
            S_EX_RD: begin
                ra = '0;
                rb = AW'(count_reg - 1'b1);
                dn_phase_next = 1'b0;
                state_next = S_DN_WAIT;
            end
            S_DN_WAIT: begin
                if (dn_phase_reg) begin
                    // finish sift-up swap: old parent goes to child slot
                    we = 1'b1;
                    waddr = pos_reg;
                    wdata = {pk_reg, pt_reg};
                    pos_next = parent;
                    dn_phase_next = 1'b0;
                    state_next = S_UP_RD;
                end else begin
                    okey_next = ka;
                    otag_next = ta;
                    we = 1'b1;
                    waddr = '0;
                    wdata = rdb;
                    pk_next = kb;
                    pt_next = tb;
                    count_next = count_reg - 1'b1;
                    pos_next = '0;
                    state_next = S_DN_RD;
                end
            end
            // Sift-down: read both children, parent held in pk/pt
            S_DN_RD: begin
                if (lchild >= (CW+1)'(count_reg)) begin
                    state_next = S_OUT;
                end else begin
                    ra = AW'(lchild);
                    rb = AW'(rchild);
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                ra = AW'(lchild);
                rb = AW'(rchild);
                dn_phase_next = 1'b1;
                state_next = S_SC_WAIT;
            end
            S_SC_WAIT: begin
                if (dn_phase_reg) begin
                    dn_phase_next = 1'b0;
                    if ((rchild < (CW+1)'(count_reg)) && (kb < ka)) begin
                        if (pk_reg <= kb) begin
                            state_next = S_OUT;
                        end else begin
                            we = 1'b1;
                            waddr = pos_reg;
                            wdata = rdb;
                            pos_next = AW'(rchild);
                            state_next = S_SC_CMP;
                        end
                    end else if (pk_reg <= ka) begin
                        state_next = S_OUT;
                    end else begin
                        we = 1'b1;
                        waddr = pos_reg;
                        wdata = rda;
                        pos_next = AW'(lchild);
                        state_next = S_SC_CMP;
                    end
                end else begin
                    // scan compare
                    if (ta == tgt_reg) begin
                        we = 1'b1;
                        waddr = AW'(scan_reg);
                        wdata = {key_reg, ta};
                        pos_next = AW'(scan_reg);
                        fromscan_next = 1'b1;
                        state_next = S_UP_RD;
                    end else begin
                        state_next = S_SC_RD;
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_SC_CMP: begin
                // place held parent entry at its new slot, continue down
                we = 1'b1;
                waddr = pos_reg;
                wdata = {pk_reg, pt_reg};
                state_next = S_DN_RD;
            end
            // Decrease-key scan
            S_SC_RD: begin
                if (scan_reg >= count_reg) begin
                    state_next = S_OUT;
                end else begin
                    ra = AW'(scan_reg);
                    dn_phase_next = 1'b0;
                    state_next = S_SC_WAIT;
                end
            end
            S_OUT: begin
                if (!ov_reg) begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/mhpq_ram.sv]
// Generic single-port-write, dual-port-read RAM with registered read data.
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[verif/min_heap_priority_queue_tb.sv]
// Testbench for the min-heap priority queue: table-driven directed words, then random traffic.
module min_heap_priority_queue_tb;
    import mhpq_pkg::*;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_func = FUNC_PUSH;
    logic signed [KEY_W-1:0] s_key = '0;
    logic [TAG_W-1:0]        s_target_tag = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_status;
    logic signed [KEY_W-1:0] m_min_key;
    logic [TAG_W-1:0]        m_min_tag;

    min_heap_priority_queue uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } outcome_t;

    typedef struct {
        logic [1:0]              func;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        bit                      typed;
        outcome_t                want;
    } dir_row_t;

    // Shadow heap
    logic signed [KEY_W-1:0] hk [CAPACITY];
    logic [TAG_W-1:0]        ht [CAPACITY];
    int                      heap_len = 0;
    logic [TAG_W-1:0]        op_seq = '0;
    outcome_t                pending_q [$];
    outcome_t                typed_q [$];
    bit                      typed_flag_q [$];

    int  errors = 0;
    int  tx_idle_pct = 11;
    int  rx_idle_pct = 55;
    bit  rx_hold = 1'b0;
    longint cycles = 0;

    function automatic bit ent_lt(int a, int b);
        if (hk[a] != hk[b]) return hk[a] < hk[b];
        return ht[a] < ht[b];
    endfunction

    function automatic void swap_ent(int a, int b);
        logic signed [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        k = hk[a]; hk[a] = hk[b]; hk[b] = k;
        t = ht[a]; ht[a] = ht[b]; ht[b] = t;
    endfunction

    function automatic void bubble_up(int p);
        int par;
        while (p > 0) begin
            par = (p - 1) / 2;
            if (!ent_lt(p, par)) return;
            swap_ent(p, par);
            p = par;
        end
    endfunction

    function automatic void bubble_down();
        int p, l, c;
        p = 0;
        while (2 * p + 1 < heap_len) begin
            l = 2 * p + 1;
            c = l;
            if (l + 1 < heap_len && hk[l + 1] < hk[l]) c = l + 1;
            if (hk[p] <= hk[c]) return;
            swap_ent(p, c);
            p = c;
        end
    endfunction

    // Apply one accepted word to the shadow heap and return its outcome
    function automatic outcome_t heap_apply(logic [1:0] f, logic signed [KEY_W-1:0] k,
                                            logic [TAG_W-1:0] tg);
        outcome_t o;
        o = '{status: ST_DONE, key: '0, tag: '0};
        op_seq = op_seq + 1'b1;
        if (f == FUNC_PUSH) begin
            if (heap_len >= CAPACITY) o.status = ST_FULL;
            else begin
                hk[heap_len] = k;
                ht[heap_len] = op_seq;
                bubble_up(heap_len);
                heap_len++;
            end
        end else if (f == FUNC_EXTRACT) begin
            if (heap_len == 0) o.status = ST_EMPTY;
            else begin
                o.status = ST_EXTRACTED;
                o.key = hk[0];
                o.tag = ht[0];
                swap_ent(heap_len - 1, 0);
                heap_len--;
                bubble_down();
            end
        end else if (f == FUNC_DECREASE) begin
            for (int i = 0; i < heap_len; i++)
                if (ht[i] == tg) begin
                    hk[i] = k;
                    bubble_up(i);
                end
        end
        return o;
    endfunction

    // Offer one word; hold it until accepted
    task automatic send_word(logic [1:0] f, logic signed [KEY_W-1:0] k, logic [TAG_W-1:0] tg,
                             bit typed, outcome_t want);
        outcome_t o;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_key <= k;
        s_target_tag <= tg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        o = heap_apply(f, k, tg);
        pending_q.push_back(o);
        typed_q.push_back(want);
        typed_flag_q.push_back(typed);
    endtask

    task automatic send_rand(logic [1:0] f);
        logic [TAG_W-1:0] tg;
        logic signed [KEY_W-1:0] k;
        tg = (heap_len > 0 && $urandom_range(3) != 0) ? ht[$urandom_range(heap_len - 1)]
                                                      : TAG_W'($urandom);
        case ($urandom_range(3))
            0: k = $urandom;
            1: k = $signed($urandom_range(40)) - 20;
            2: k = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: k = $signed($urandom_range(2000)) - 1000;
        endcase
        send_word(f, k, tg, 1'b0, '0);
    endtask

    // Receiver: random ready, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Result checker
    always @(posedge aclk) begin
        outcome_t want, got;
        bit typed;
        outcome_t tw;
        if (aresetn && m_valid && m_ready) begin
            got = '{status: m_status, key: m_min_key, tag: m_min_tag};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word status=%0d key=%0d tag=%0h",
                         $time, got.status, got.key, got.tag);
                errors++;
            end else begin
                want = pending_q.pop_front();
                typed = typed_flag_q.pop_front();
                tw = typed_q.pop_front();
                if (typed && tw != want) begin
                    $display("%0t: table row disagrees exp=%p model=%p", $time, tw, want);
                    errors++;
                end
                if (got.status != want.status) begin
                    $display("%0t: status exp=%0d act=%0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.key != want.key) begin
                    $display("%0t: min_key exp=%0d act=%0d", $time, want.key, got.key);
                    errors++;
                end
                if (got.tag != want.tag) begin
                    $display("%0t: min_tag exp=%0h act=%0h", $time, want.tag, got.tag);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd10000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    dir_row_t rows [$];

    function automatic void add_row(logic [1:0] f, logic signed [KEY_W-1:0] k,
                                    logic [TAG_W-1:0] tg, bit typed, outcome_t w);
        dir_row_t r;
        r.func = f; r.key = k; r.tag = tg; r.typed = typed; r.want = w;
        rows.push_back(r);
    endfunction

    initial begin
        outcome_t nil;
        nil = '0;
        // Directed table: tags are the operation number
        add_row(FUNC_EXTRACT, 0, 0, 1, '{ST_EMPTY, 0, 0});            // empty extract
        add_row(FUNC_PUSH, 32'sh7fffffff, 0, 1, '{ST_DONE, 0, 0});    // tag 2
        add_row(FUNC_PUSH, 32'sh80000000, 24'hffffff, 1, '{ST_DONE, 0, 0}); // tag 3
        add_row(FUNC_PUSH, 5, 0, 1, '{ST_DONE, 0, 0});                // tag 4
        add_row(FUNC_PUSH, 5, 0, 1, '{ST_DONE, 0, 0});                // tag 5, key tie
        add_row(2'd3, -1, 24'hffffff, 1, '{ST_DONE, 0, 0});           // unused code
        add_row(FUNC_DECREASE, -7, 24'h123456, 1, '{ST_DONE, 0, 0});  // no matching tag
        add_row(FUNC_DECREASE, -100, 5, 0, nil);                      // decrease tag 5
        add_row(FUNC_DECREASE, 32'sh7ffffff0, 3, 0, nil);             // key grows at root
        add_row(FUNC_EXTRACT, 0, 0, 1, '{ST_EXTRACTED, 32'sh7ffffff0, 3});
        add_row(FUNC_EXTRACT, 0, 0, 0, nil);
        add_row(FUNC_EXTRACT, 0, 0, 0, nil);
        add_row(FUNC_EXTRACT, 0, 0, 0, nil);
        add_row(FUNC_EXTRACT, 0, 0, 1, '{ST_EMPTY, 0, 0});
        add_row(FUNC_PUSH, 0, 24'haaaaaa, 0, nil);
        add_row(FUNC_DECREASE, 32'sh55555555, 24'h555555, 0, nil);
        add_row(FUNC_EXTRACT, 0, 0, 0, nil);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_word(rows[i].func, rows[i].key, rows[i].tag,
                                    rows[i].typed, rows[i].want);

        // Random traffic in three idle phases; weight toward pushes and extracts
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 55 : 0;
            rx_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 11 : 0;
            for (int n = 0; n < 160; n++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: send_rand(FUNC_PUSH);
                    4, 5, 6:    send_rand(FUNC_EXTRACT);
                    7, 8:       send_rand(FUNC_DECREASE);
                    default:    send_rand(2'd3);
                endcase
            end
        end

        // Long receiver hold-off while pushes keep coming
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end
            for (int n = 0; n < 40; n++) send_rand(FUNC_PUSH);
        join

        // A decrease-key on a crowded heap, then drain a few
        send_rand(FUNC_DECREASE);
        for (int n = 0; n < 20; n++) send_rand(FUNC_EXTRACT);
        s_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
